// ===== rtl/sla_pkg.sv =====
package sla_pkg;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_RETURN  = 8'h0D;

	localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
	localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

	typedef enum logic [1:0] {
		EV_BYTE = 2'd0,
		EV_UP   = 2'd1,
		EV_LOST = 2'd2
	} event_t;

	typedef enum logic [0:0] {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOST,
		ST_UP,
		ST_RD,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/serial_line_assembler_with_watchdog.sv =====
// A beat is accepted in any cycle in which the block is idle.
// A tick or a plain byte keeps the block busy only when it raises a link event.
// A link event is loaded into the output register from ST_UP or ST_LOST once that register is free.
// A newline closing a non-empty line holds off input until its bytes are out, after ST_UP on link-up;
// bytes pass ST_RD then ST_EMIT, as the memory read port is registered; output stalls add to this.
// Reset clears the line length, link state and silence count, and sets the timeout to 3000.
module serial_line_assembler_with_watchdog #(
	parameter int LINE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,      // silence_timeout_ticks
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // line_byte
	output logic [1:0]  m_axis_tuser,   // event_res
	output logic        m_axis_tlast    // line_last
);
	import sla_pkg::*;

	localparam int AW = (LINE_BYTES > 2) ? $clog2(LINE_BYTES) : 1;
	localparam logic [AW-1:0] LEN_MAX = AW'(LINE_BYTES - 1);

	logic [7:0]    line_mem [LINE_BYTES];
	logic [7:0]    rd_data_q;

	state_t        state_q, state_d;
	logic [AW-1:0] line_len_q;
	logic          last_cr_q;
	logic          link_up_q;
	logic [15:0]   silence_q;
	logic [15:0]   timeout_q;
	logic          nl_q;
	logic [AW-1:0] emit_len_q;
	logic [AW-1:0] idx_q;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	event_t        out_ev_q;
	logic          out_last_q;

	logic          accept;
	logic          is_tick;
	logic          is_nl;
	logic [15:0]   silence_inc;
	logic          lost;
	logic          mem_we;
	logic          free;
	logic          load;
	event_t        load_ev;
	logic [7:0]    load_byte;
	logic          load_last;
	logic          idx_last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_tick       = (kind_t'(s_axis_tuser) == KIND_TICK);
	assign is_nl         = (s_axis_tdata == CH_NEWLINE);
	assign silence_inc   = (silence_q == SILENCE_MAX) ? silence_q : silence_q + 16'd1;
	assign lost          = link_up_q && (silence_inc >= timeout_q);
	assign mem_we        = accept && !is_tick && !is_nl && (line_len_q < LEN_MAX);
	assign free          = !out_valid_q || m_axis_tready;
	assign idx_last      = (idx_q == emit_len_q - AW'(1));

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		load_ev   = EV_BYTE;
		load_byte = 8'h00;
		load_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_tick) begin
						if (lost) begin
							state_d = ST_LOST;
						end
					end else if (!link_up_q) begin
						state_d = ST_UP;
					end else if (is_nl && (line_len_q - AW'(last_cr_q)) != '0) begin
						state_d = ST_RD;
					end
				end
			end
			ST_LOST: begin
				if (free) begin
					load    = 1'b1;
					load_ev = EV_LOST;
					state_d = ST_IDLE;
				end
			end
			ST_UP: begin
				if (free) begin
					load    = 1'b1;
					load_ev = EV_UP;
					state_d = (nl_q && emit_len_q != '0) ? ST_RD : ST_IDLE;
				end
			end
			ST_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (free) begin
					load      = 1'b1;
					load_ev   = EV_BYTE;
					load_byte = rd_data_q;
					load_last = idx_last;
					state_d   = idx_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			last_cr_q  <= 1'b0;
			link_up_q  <= 1'b0;
			silence_q  <= '0;
			timeout_q  <= TIMEOUT_RESET;
			nl_q       <= 1'b0;
			emit_len_q <= '0;
			idx_q      <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (accept) begin
				if (is_tick) begin
					silence_q <= silence_inc;
					if (lost) begin
						link_up_q <= 1'b0;
					end
				end else begin
					silence_q <= '0;
					link_up_q <= 1'b1;
					nl_q      <= is_nl;
					idx_q     <= '0;
					if (is_nl) begin
						emit_len_q <= line_len_q - AW'(last_cr_q);
						line_len_q <= '0;
						last_cr_q  <= 1'b0;
					end else if (line_len_q < LEN_MAX) begin
						line_len_q <= line_len_q + AW'(1);
						last_cr_q  <= (s_axis_tdata == CH_RETURN);
					end else begin
						line_len_q <= '0;
						last_cr_q  <= 1'b0;
					end
				end
			end
			if (state_q == ST_EMIT && free && !idx_last) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[line_len_q] <= s_axis_tdata;
		end
		rd_data_q <= line_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= load_byte;
			out_ev_q   <= load_ev;
			out_last_q <= load_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== tb/tb_serial_line_assembler_with_watchdog.sv =====
module tb_serial_line_assembler_with_watchdog;
	timeunit 1ns;
	timeprecision 1ps;

	import sla_pkg::*;

	localparam int LINE_BYTES = 64;
	localparam int DRAIN_CYCLES = 2 * LINE_BYTES + 8;
	localparam int HOLD_CYCLES = 600;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		int unsigned gap;
	} rx_item_t;

	typedef struct {
		event_t     ev;
		logic [7:0] data;
		logic       last;
	} line_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	rx_item_t    rx_pending[$];
	line_event_t expected_events[$];
	line_event_t oldest_event;

	logic [7:0]  line_copy [LINE_BYTES];
	int unsigned line_fill = 0;
	bit          link_alive = 1'b0;
	int unsigned quiet_ticks = 0;
	logic [15:0] timeout_ticks = TIMEOUT_RESET;

	bit          src_idles = 1'b0;
	bit          sink_idles = 1'b0;
	bit          sink_hold = 1'b0;
	bit          hold_go = 1'b0;
	int unsigned sink_wait = 0;
	int unsigned sink_next_wait;
	int unsigned queued_count = 0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;

	serial_line_assembler_with_watchdog #(
		.LINE_BYTES(LINE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	function automatic void assemble_rx(kind_t kind, logic [7:0] data);
		int unsigned keep;
		if (kind == KIND_TICK) begin
			if (quiet_ticks < SILENCE_MAX)
				quiet_ticks++;
			if (link_alive && quiet_ticks >= timeout_ticks) begin
				link_alive = 1'b0;
				expected_events.push_back(line_event_t'{EV_LOST, 8'h00, 1'b0});
			end
			return;
		end
		quiet_ticks = 0;
		if (!link_alive) begin
			link_alive = 1'b1;
			expected_events.push_back(line_event_t'{EV_UP, 8'h00, 1'b0});
		end
		if (data == CH_NEWLINE) begin
			keep = line_fill;
			if (keep > 0 && line_copy[keep - 1] == CH_RETURN)
				keep--;
			for (int unsigned i = 0; i < keep; i++)
				expected_events.push_back(line_event_t'{EV_BYTE, line_copy[i], i + 1 == keep});
			line_fill = 0;
		end else if (line_fill < LINE_BYTES - 1) begin
			line_copy[line_fill] = data;
			line_fill++;
		end else begin
			line_fill = 0;
		end
	endfunction

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				assemble_rx(kind_t'(s_axis_tuser), s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (rx_pending.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (rx_pending[0].gap != 0) begin
					rx_pending[0].gap = rx_pending[0].gap - 1;
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= rx_pending[0].kind;
					s_axis_tdata <= rx_pending[0].data;
					void'(rx_pending.pop_front());
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_wait <= 0;
		end else begin
			sink_next_wait = sink_wait;
			if (m_axis_tvalid && m_axis_tready) begin
				sink_next_wait = sink_idles ? $urandom_range(0, 19) : 0;
				if (expected_events.size() == 0) begin
					note_fault($sformatf("unexpected beat: event %0d byte %02h last %0b",
						m_axis_tuser, m_axis_tdata, m_axis_tlast));
				end else begin
					oldest_event = expected_events.pop_front();
					if (m_axis_tuser !== oldest_event.ev || m_axis_tdata !== oldest_event.data
							|| m_axis_tlast !== oldest_event.last)
						note_fault($sformatf({"beat mismatch: expected event %0d byte %02h last %0b,",
							" got event %0d byte %02h last %0b"}, oldest_event.ev,
							oldest_event.data, oldest_event.last, m_axis_tuser, m_axis_tdata,
							m_axis_tlast));
				end
			end
			if (sink_hold || sink_next_wait != 0)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= 1'b1;
			sink_wait <= (sink_next_wait != 0 && !sink_hold) ? sink_next_wait - 1 : sink_next_wait;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// The receiver stops taking beats for a long stretch while lines keep arriving.
	initial begin
		wait (hold_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	task automatic queue_item(kind_t kind, logic [7:0] data);
		rx_pending.push_back(rx_item_t'{kind, data, src_idles ? $urandom_range(0, 19) : 0});
		queued_count++;
	endtask

	task automatic queue_ticks(int unsigned count);
		repeat (count) queue_item(KIND_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic queue_line(int unsigned len, bit with_return);
		logic [7:0] b;
		repeat (len) begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_NEWLINE)
				b = b ^ 8'h01;
			queue_item(KIND_BYTE, b);
		end
		if (with_return)
			queue_item(KIND_BYTE, CH_RETURN);
		queue_item(KIND_BYTE, CH_NEWLINE);
	endtask

	task automatic queue_random_traffic(int unsigned budget);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		stop_at = queued_count + budget;
		while (queued_count < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					len = $urandom_range(0, 10);
				else if (pick < 92)
					len = $urandom_range(11, 40);
				else
					len = $urandom_range(LINE_BYTES - 3, LINE_BYTES + 1);
				queue_line(len, $urandom_range(0, 3) == 0);
			end else if (pick < 80) begin
				queue_ticks($urandom_range(1, timeout_ticks + 3));
			end else begin
				pick = $urandom_range(0, 3);
				if (pick == 0)
					queue_item(KIND_TICK, 8'($urandom_range(0, 255)));
				else if (pick == 1)
					queue_item(KIND_BYTE, CH_NEWLINE);
				else if (pick == 2)
					queue_item(KIND_BYTE, CH_RETURN);
				else
					queue_item(KIND_BYTE, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (rx_pending.size() != 0 || s_axis_tvalid || expected_events.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(logic [15:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		timeout_ticks = value;
		@(negedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		src_idles = 1'b1;
		sink_idles = 1'b1;
		queue_item(KIND_BYTE, 8'h00);
		queue_item(KIND_BYTE, 8'hFF);
		queue_item(KIND_BYTE, CH_RETURN);
		queue_item(KIND_BYTE, CH_NEWLINE);
		queue_item(KIND_BYTE, CH_NEWLINE);
		queue_item(KIND_BYTE, CH_RETURN);
		queue_item(KIND_BYTE, CH_NEWLINE);
		queue_item(KIND_BYTE, CH_RETURN);
		queue_item(KIND_BYTE, CH_RETURN);
		queue_item(KIND_BYTE, CH_NEWLINE);
		queue_item(KIND_BYTE, 8'h55);
		queue_item(KIND_BYTE, 8'hAA);
		queue_item(KIND_TICK, 8'hFF);
		queue_item(KIND_BYTE, CH_NEWLINE);

		// Silence well short of the reset timeout keeps the link up.
		src_idles = 1'b0;
		queue_ticks(20);
		queue_ticks(2);
		queue_item(KIND_BYTE, CH_NEWLINE);

		write_timeout(16'd1);
		src_idles = 1'b1;
		queue_item(KIND_BYTE, 8'h41);
		queue_item(KIND_TICK, 8'h00);
		queue_item(KIND_TICK, 8'h00);
		queue_item(KIND_BYTE, 8'h42);
		queue_item(KIND_BYTE, CH_NEWLINE);

		write_timeout(16'd0);
		queue_item(KIND_BYTE, 8'h80);
		queue_item(KIND_TICK, 8'h00);
		queue_item(KIND_TICK, 8'h00);
		queue_item(KIND_BYTE, CH_NEWLINE);

		write_timeout(16'hFFFF);
		src_idles = 1'b0;
		sink_idles = 1'b0;
		queue_item(KIND_BYTE, 8'h7F);
		queue_ticks(30);
		queue_ticks(3);
		queue_item(KIND_BYTE, CH_NEWLINE);

		write_timeout(16'd2);
		src_idles = 1'b1;
		sink_idles = 1'b1;
		queue_random_traffic(80);

		write_timeout(16'd5);
		src_idles = 1'b0;
		hold_go = 1'b1;
		queue_random_traffic(80);

		write_timeout(16'($urandom_range(1, 40)));
		src_idles = 1'b1;
		sink_idles = 1'b0;
		queue_random_traffic(80);

		write_timeout(16'd13);
		src_idles = 1'b0;
		queue_random_traffic(70);

		wait_drained();
		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
